/* hw/rtl/sqlsplit_pkg.sv */
// Shared types, character codes and helpers for the SQL statement splitter.
package sqlsplit_pkg;

   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE   = 8'h27;

   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_QUOTE   = 3'd1;
   localparam logic [2:0] MODE_QCLOSE  = 3'd2;
   localparam logic [2:0] MODE_DASH    = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;

   localparam int QUEUE_DEPTH = 3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       statement_end;
      logic       script_done;
      logic       unterminated;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic result_type byte_word(input logic [7:0] b);
      result_type r;
      r = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      return r;
   endfunction

endpackage

/* hw/rtl/sqlsplit_req_if.sv */
// Input channel: one script byte or an end-of-script marker per word.
interface sqlsplit_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source(output valid, output in_byte, output end_of_input, input ready);
   modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

/* hw/rtl/sqlsplit_rsp_if.sv */
// Result channel: one statement byte, statement end or script report per word.
interface sqlsplit_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       statement_end;
   logic       script_done;
   logic       unterminated;
   logic       last;

   modport source(output valid, output out_byte, output byte_valid, output statement_end,
                  output script_done, output unterminated, output last, input ready);
   modport sink(input valid, input out_byte, input byte_valid, input statement_end,
                input script_done, input unterminated, input last, output ready);
endinterface

/* hw/rtl/sqlsplit_scan.sv */
// Scanner state and the per-byte decode into zero, one or two result words.
module sqlsplit_scan
   import sqlsplit_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_input,
   output push_type   push
);

   logic [2:0] mode_ff, mode_in;
   logic       newline_ff, newline_in;
   logic       pending_ff, pending_in;

   result_type r0, r1, norm_res;
   logic [1:0] n;
   logic       norm_nl, norm_emit;
   logic [2:0] norm_mode;

   always_comb begin
      // Plain-text handling of the byte; newline context only counts in normal mode.
      norm_nl   = (mode_ff == MODE_NORMAL || mode_ff > MODE_COMMENT) ? newline_ff : 1'b0;
      norm_res  = '0;
      norm_emit = 1'b0;
      norm_mode = MODE_NORMAL;
      if (in_byte == CHAR_DASH && norm_nl) begin
         norm_mode = MODE_DASH;
      end else if (in_byte == CHAR_SEMI) begin
         norm_res.statement_end = 1'b1;
         norm_emit = 1'b1;
      end else begin
         norm_res  = byte_word(in_byte);
         norm_emit = 1'b1;
         norm_mode = (in_byte == CHAR_QUOTE) ? MODE_QUOTE : MODE_NORMAL;
      end
   end

   always_comb begin
      r0         = '0;
      r1         = '0;
      n          = 2'd0;
      mode_in    = mode_ff;
      newline_in = (in_byte == CHAR_NEWLINE);
      pending_in = pending_ff;
      if (end_of_input) begin
         r0.script_done  = 1'b1;
         r0.unterminated = pending_ff;
         n          = 2'd1;
         mode_in    = MODE_NORMAL;
         newline_in = 1'b1;
         pending_in = 1'b0;
      end else begin
         case (mode_ff)
            MODE_QUOTE: begin
               if (in_byte == CHAR_QUOTE) begin
                  mode_in = MODE_QCLOSE;
               end else begin
                  r0 = byte_word(in_byte);
                  n  = 2'd1;
                  if (!is_space(in_byte)) pending_in = 1'b1;
               end
            end
            MODE_QCLOSE, MODE_DASH: begin
               // Release the held quote or dash first, then handle the byte.
               r0 = byte_word((mode_ff == MODE_QCLOSE) ? CHAR_QUOTE : CHAR_DASH);
               n  = 2'd1;
               pending_in = 1'b1;
               if (mode_ff == MODE_QCLOSE && in_byte == CHAR_QUOTE) begin
                  r1      = byte_word(CHAR_QUOTE);
                  n       = 2'd2;
                  mode_in = MODE_QUOTE;
               end else if (mode_ff == MODE_DASH && in_byte == CHAR_DASH) begin
                  r0      = '0;
                  n       = 2'd0;
                  pending_in = pending_ff;
                  mode_in = MODE_COMMENT;
               end else begin
                  r1      = norm_res;
                  n       = norm_emit ? 2'd2 : 2'd1;
                  mode_in = norm_mode;
                  if (in_byte == CHAR_SEMI) pending_in = 1'b0;
               end
            end
            MODE_COMMENT: begin
               if (in_byte == CHAR_NEWLINE) mode_in = MODE_NORMAL;
            end
            default: begin
               r0      = norm_res;
               n       = norm_emit ? 2'd1 : 2'd0;
               mode_in = norm_mode;
               if (in_byte == CHAR_SEMI) begin
                  pending_in = 1'b0;
               end else if (norm_emit && !is_space(in_byte)) begin
                  pending_in = 1'b1;
               end
            end
         endcase
      end
      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;
      push.count  = accept ? n : 2'd0;
      push.first  = r0;
      push.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         newline_ff <= 1'b1;
         pending_ff <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         newline_ff <= newline_in;
         pending_ff <= pending_in;
      end
   end

endmodule

/* hw/rtl/sqlsplit_rsp_queue.sv */
// Three-word result queue; takes up to two words per cycle, hands out one.
module sqlsplit_rsp_queue
   import sqlsplit_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       space_ok,
   output logic       head_valid,
   output result_type head
);

   result_type q_ff [QUEUE_DEPTH];
   result_type q_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] base;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) q_in[i] = q_ff[i];
      base = count_ff;
      if (pop && count_ff != 2'd0) begin
         // Advance the queue one place.
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_in[i] = q_ff[i + 1];
         base = count_ff - 2'd1;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push.count != 2'd0 && base == 2'(i)) q_in[i] = push.first;
         if (push.count == 2'd2 && base + 2'd1 == 2'(i)) q_in[i] = push.second;
      end
      count_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) q_ff[i] <= q_in[i];
   end

   assign space_ok   = (count_ff <= 2'd1);
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[0];

endmodule

/* hw/rtl/sql_script_statement_splitter_unit.sv */
// SQL script statement splitter: takes one script byte per cycle while req_if.ready is
// high and registers its result words into a three-word queue as the byte is taken. With
// rsp_if.ready held high, a byte that yields one result (or none) sustains one byte per
// cycle; one yielding two (a released quote or dash and the next byte) leaves two words queued,
// so req_if.ready drops for one cycle while they drain. Ready depends only on the fill level.
module sql_script_statement_splitter_unit
   import sqlsplit_pkg::*;
(
   input logic     clock,
   input logic     reset,
   sqlsplit_req_if.sink   req_if,
   sqlsplit_rsp_if.source rsp_if
);

   push_type   push;
   result_type head;
   logic       space_ok;
   logic       head_valid;
   logic       accept;

   assign req_if.ready = space_ok;
   assign accept       = req_if.valid && space_ok;

   sqlsplit_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_if.in_byte),
      .end_of_input (req_if.end_of_input),
      .push         (push)
   );

   sqlsplit_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_if.ready),
      .space_ok   (space_ok),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_if.valid         = head_valid;
   assign rsp_if.out_byte      = head.out_byte;
   assign rsp_if.byte_valid    = head.byte_valid;
   assign rsp_if.statement_end = head.statement_end;
   assign rsp_if.script_done   = head.script_done;
   assign rsp_if.unterminated  = head.unterminated;
   assign rsp_if.last          = head.last;

endmodule
